/* rtl/mtg_pkg.sv */
// Shared types and constants for the slot-0 multitouch gesture decoder.
// No dependencies; compiled first.
`default_nettype none

package mtg_pkg;

  // Fixed point format of normalized coordinates
  localparam int FRACTION_BITS = 16;
  localparam int NORM_W        = FRACTION_BITS + 1;
  localparam int CNT_W         = $clog2(FRACTION_BITS);

  // Payload widths
  localparam int TYPE_W  = 5;
  localparam int CODE_W  = 10;
  localparam int VALUE_W = 32;
  localparam int DATA_W  = 32;
  localparam int PADDR_W = 4;

  // Event classes and codes
  localparam logic [TYPE_W-1:0] TYPE_SYN    = 5'd0;
  localparam logic [TYPE_W-1:0] TYPE_ABS    = 5'd3;
  localparam logic [CODE_W-1:0] CODE_REPORT = 10'h000;
  localparam logic [CODE_W-1:0] CODE_SLOT   = 10'h02f;
  localparam logic [CODE_W-1:0] CODE_TRACK  = 10'h039;
  localparam logic [CODE_W-1:0] CODE_POS_X  = 10'h035;
  localparam logic [CODE_W-1:0] CODE_POS_Y  = 10'h036;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_DOWN = 2'd0,
    KIND_UP   = 2'd1,
    KIND_MOVE = 2'd2
  } kind_t;

  // Register map, index = paddr[3:2]
  typedef enum logic [1:0] {
    REG_X_MIN = 2'd0,
    REG_X_MAX = 2'd1,
    REG_Y_MIN = 2'd2,
    REG_Y_MAX = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] x_minimum;
    logic signed [VALUE_W-1:0] x_maximum;
    logic signed [VALUE_W-1:0] y_minimum;
    logic signed [VALUE_W-1:0] y_maximum;
  } cfg_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_LOAD
  } state_t;

  // Controller -> datapath
  typedef struct packed {
    logic accept;    // input beat taken
    logic capture;   // report needs a result: latch operands
    logic prep;      // range checks, divider init
    logic step;      // one quotient bit
    logic load_out;  // move result into output register
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic report_emit;  // offered beat is a report that yields a result
    logic out_free;     // output register can take a result this cycle
  } status_t;

endpackage

`default_nettype wire

/* rtl/mtg_if.sv */
// Valid/ready channel interfaces for input events and result beats.
// Depends on mtg_pkg.
`default_nettype none

interface mtg_evt_if;
  import mtg_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [TYPE_W-1:0]         event_type;
  logic [CODE_W-1:0]         event_code;
  logic signed [VALUE_W-1:0] event_value;

  modport source (output valid, event_type, event_code, event_value, input ready);
  modport sink   (input valid, event_type, event_code, event_value, output ready);
endinterface

interface mtg_res_if;
  import mtg_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        touch_kind;
  logic [NORM_W-1:0] norm_x;
  logic [NORM_W-1:0] norm_y;

  modport source (output valid, touch_kind, norm_x, norm_y, input ready);
  modport sink   (input valid, touch_kind, norm_x, norm_y, output ready);
endinterface

`default_nettype wire

/* rtl/mtg_cfg.sv */
// APB register file holding the X/Y axis ranges.
// Depends on mtg_pkg.
`default_nettype none

module mtg_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mtg_pkg::PADDR_W-1:0]  paddr,
  input  logic [mtg_pkg::DATA_W-1:0]   pwdata,
  output logic [mtg_pkg::DATA_W-1:0]   prdata,
  output mtg_pkg::cfg_t                cfg
);
  import mtg_pkg::*;

  reg_idx_t idx;
  logic     wr_en;

  assign idx   = reg_idx_t'(paddr[3:2]);
  assign wr_en = psel && penable && pwrite;

  // register writes at the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_X_MIN: cfg.x_minimum <= pwdata;
        REG_X_MAX: cfg.x_maximum <= pwdata;
        REG_Y_MIN: cfg.y_minimum <= pwdata;
        REG_Y_MAX: cfg.y_maximum <= pwdata;
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (idx)
      REG_X_MIN: prdata = cfg.x_minimum;
      REG_X_MAX: prdata = cfg.x_maximum;
      REG_Y_MIN: prdata = cfg.y_minimum;
      REG_Y_MAX: prdata = cfg.y_maximum;
      default:   prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/mtg_div.sv */
// One normalization lane: range check and restoring divider, one quotient bit per step.
// Depends on mtg_pkg.
`default_nettype none

module mtg_div (
  input  logic                               clk,
  input  logic                               capture,
  input  logic                               prep,
  input  logic                               step,
  input  logic signed [mtg_pkg::VALUE_W-1:0] value,
  input  logic signed [mtg_pkg::VALUE_W-1:0] lo,
  input  logic signed [mtg_pkg::VALUE_W-1:0] hi,
  output logic [mtg_pkg::NORM_W-1:0]         norm
);
  import mtg_pkg::*;

  logic signed [VALUE_W:0]    d;
  logic signed [VALUE_W:0]    r;
  logic                       sat_zero;
  logic                       sat_full;
  logic [VALUE_W-1:0]         rem;
  logic [VALUE_W-1:0]         div_r;
  logic [FRACTION_BITS-1:0]   quo;
  logic [VALUE_W:0]           shifted;
  logic                       ge;
  logic [VALUE_W:0]           diff;

  assign shifted = {rem, 1'b0};
  assign ge      = shifted >= {1'b0, div_r};
  assign diff    = shifted - {1'b0, div_r};

  always_ff @(posedge clk) begin
    // exact offsets, one bit wider than the raw values
    if (capture) begin
      d <= {value[VALUE_W-1], value} - {lo[VALUE_W-1], lo};
      r <= {hi[VALUE_W-1], hi} - {lo[VALUE_W-1], lo};
    end
    // empty range or below minimum gives zero; at or past maximum gives one
    if (prep) begin
      sat_zero <= (r[VALUE_W] || r == '0) || (d[VALUE_W] || d == '0);
      sat_full <= d >= r;
      rem      <= d[VALUE_W-1:0];
      div_r    <= r[VALUE_W-1:0];
    end
    // restoring step
    if (step) begin
      rem <= ge ? diff[VALUE_W-1:0] : shifted[VALUE_W-1:0];
      quo <= {quo[FRACTION_BITS-2:0], ge};
    end
  end

  always_comb begin
    if (sat_zero) begin
      norm = '0;
    end else if (sat_full) begin
      norm = NORM_W'(1) << FRACTION_BITS;
    end else begin
      norm = {1'b0, quo};
    end
  end

endmodule

`default_nettype wire

/* rtl/mtg_dp.sv */
// Datapath: slot-0 contact state, two normalization lanes, output register.
// Depends on mtg_pkg and mtg_div.
`default_nettype none

module mtg_dp (
  input  logic                               clk,
  input  logic                               rst,
  input  mtg_pkg::cmd_t                      cmd,
  output mtg_pkg::status_t                   status,
  input  mtg_pkg::cfg_t                      cfg,
  input  logic [mtg_pkg::TYPE_W-1:0]         event_type,
  input  logic [mtg_pkg::CODE_W-1:0]         event_code,
  input  logic signed [mtg_pkg::VALUE_W-1:0] event_value,
  input  logic                               res_ready,
  output logic                               res_valid,
  output logic [1:0]                         touch_kind,
  output logic [mtg_pkg::NORM_W-1:0]         norm_x,
  output logic [mtg_pkg::NORM_W-1:0]         norm_y
);
  import mtg_pkg::*;

  logic                      slot_is_zero;
  logic                      contact_active;
  logic signed [VALUE_W-1:0] current_x;
  logic signed [VALUE_W-1:0] current_y;
  logic                      was_touching;
  logic signed [VALUE_W-1:0] previous_x;
  logic signed [VALUE_W-1:0] previous_y;
  kind_t                     kind;
  kind_t                     kind_next;
  logic                      is_abs;
  logic                      is_report;
  logic                      emit;
  logic [NORM_W-1:0]         lane_x;
  logic [NORM_W-1:0]         lane_y;

  assign is_abs    = event_type == TYPE_ABS;
  assign is_report = event_type == TYPE_SYN && event_code == CODE_REPORT;

  // change detection against the last report
  always_comb begin
    emit      = 1'b1;
    kind_next = KIND_MOVE;
    if (contact_active && !was_touching) begin
      kind_next = KIND_DOWN;
    end else if (!contact_active && was_touching) begin
      kind_next = KIND_UP;
    end else if (!(contact_active &&
                   (current_x != previous_x || current_y != previous_y))) begin
      emit = 1'b0;
    end
  end

  assign status.report_emit = is_report && emit;
  assign status.out_free    = !res_valid || res_ready;

  // contact state, updated once per accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_is_zero   <= 1'b1;
      contact_active <= 1'b0;
      current_x      <= '0;
      current_y      <= '0;
      was_touching   <= 1'b0;
      previous_x     <= '0;
      previous_y     <= '0;
    end else if (cmd.accept) begin
      if (is_abs) begin
        unique case (event_code)
          CODE_SLOT:  slot_is_zero <= event_value == '0;
          CODE_TRACK: if (slot_is_zero) contact_active <= !event_value[VALUE_W-1];
          CODE_POS_X: if (slot_is_zero) current_x <= event_value;
          CODE_POS_Y: if (slot_is_zero) current_y <= event_value;
          default: ;
        endcase
      end else if (is_report) begin
        was_touching <= contact_active;
        previous_x   <= current_x;
        previous_y   <= current_y;
      end
    end
  end

  // kind of the result in flight
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind <= kind_next;
    end
  end

  mtg_div u_div_x (
    .clk     (clk),
    .capture (cmd.capture),
    .prep    (cmd.prep),
    .step    (cmd.step),
    .value   (current_x),
    .lo      (cfg.x_minimum),
    .hi      (cfg.x_maximum),
    .norm    (lane_x)
  );

  mtg_div u_div_y (
    .clk     (clk),
    .capture (cmd.capture),
    .prep    (cmd.prep),
    .step    (cmd.step),
    .value   (current_y),
    .lo      (cfg.y_minimum),
    .hi      (cfg.y_maximum),
    .norm    (lane_y)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.load_out) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      touch_kind <= kind;
      norm_x     <= lane_x;
      norm_y     <= lane_y;
    end
  end

endmodule

`default_nettype wire

/* rtl/mtg_ctrl.sv */
// Sequencer: input handshake, divider step count, hand-off to the output register.
// Depends on mtg_pkg.
`default_nettype none

module mtg_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               evt_valid,
  output logic               evt_ready,
  input  mtg_pkg::status_t   status,
  output mtg_pkg::cmd_t      cmd
);
  import mtg_pkg::*;

  state_t           state;
  state_t           state_next;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;

  // state and step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    evt_ready  = 1'b0;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        evt_ready = 1'b1;
        if (evt_valid) begin
          cmd.accept = 1'b1;
          if (status.report_emit) begin
            cmd.capture = 1'b1;
            state_next  = ST_PREP;
          end
        end
      end
      ST_PREP: begin
        cmd.prep   = 1'b1;
        cnt_next   = '0;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.step = 1'b1;
        cnt_next = cnt + 1'b1;
        if (cnt == CNT_W'(FRACTION_BITS - 1)) begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/multitouch_slot0_gesture_decoder_core.sv */
// Top level of the slot-0 multitouch gesture decoder.
// Depends on mtg_pkg, mtg_if, mtg_cfg, mtg_div, mtg_dp and mtg_ctrl.
`default_nettype none

// Takes one event beat at a time. Slot, tracking-id and position events are
// absorbed without holding off the input, as is a report that yields no result. A
// report that yields touch down, up or move holds off the input through the
// operand latch, range check, one restoring-divider step per quotient bit for
// X and Y in parallel, then the load into the output register, which waits
// until that register is free. The next event is taken while a result waits in
// the output register. Axis range registers sit at byte addresses 0, 4, 8 and
// 12 (X min, X max, Y min, Y max); the user must write them only while the block
// is idle, as the block itself does not enforce this.
module multitouch_slot0_gesture_decoder_core (
  input  logic                        clk,
  input  logic                        rst,
  mtg_evt_if.sink                     evt,
  mtg_res_if.source                   res,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mtg_pkg::PADDR_W-1:0] paddr,
  input  logic [mtg_pkg::DATA_W-1:0]  pwdata,
  output logic [mtg_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import mtg_pkg::*;

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  assign pready = 1'b1;

  mtg_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  mtg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .evt_valid (evt.valid),
    .evt_ready (evt.ready),
    .status    (status),
    .cmd       (cmd)
  );

  mtg_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .cfg         (cfg),
    .event_type  (evt.event_type),
    .event_code  (evt.event_code),
    .event_value (evt.event_value),
    .res_ready   (res.ready),
    .res_valid   (res.valid),
    .touch_kind  (res.touch_kind),
    .norm_x      (res.norm_x),
    .norm_y      (res.norm_y)
  );

  // a report that needs a result blocks the input until it is done
  a_busy_after_capture: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> !evt.ready)
    else $error("input taken while a result is being computed");

  // divider init is always followed by a step
  a_prep_then_step: assert property (@(posedge clk) disable iff (rst)
    cmd.prep |=> cmd.step)
    else $error("divider init not followed by a step");

  // a loaded result shows up on the result channel
  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> res.valid)
    else $error("loaded result not presented");

  // normalized coordinates never exceed one
  a_norm_range: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (res.norm_x <= (NORM_W'(1) << FRACTION_BITS)) &&
                  (res.norm_y <= (NORM_W'(1) << FRACTION_BITS)))
    else $error("normalized coordinate above one");

endmodule

`default_nettype wire

/* tb/sv/multitouch_slot0_gesture_decoder_core_tb.sv */
// Self-checking testbench for the slot-0 multitouch gesture decoder core.
// Drives event beats and APB register writes, predicts every touch result.
// Depends on mtg_pkg, mtg_if and the RTL of the core.
`default_nettype none

module multitouch_slot0_gesture_decoder_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mtg_pkg::*;

  localparam int RESET_CYCLES   = 11;
  localparam int SETTLE_CYCLES  = FRACTION_BITS + 3 + 8;
  localparam int HOLD_CYCLES    = 400;
  localparam int TIMEOUT_CYCLES = 1000000;
  localparam int TARGET_ITEMS   = 1250;
  localparam int FRAMES_PER_SET = 40;
  localparam int DIRECTED_SPLIT = 5;

  typedef struct packed {
    kind_t             kind;
    logic [NORM_W-1:0] nx;
    logic [NORM_W-1:0] ny;
  } touch_t;

  typedef struct {
    logic [TYPE_W-1:0]  etype;
    logic [CODE_W-1:0]  ecode;
    logic [VALUE_W-1:0] evalue;
    bit                 typed;  // expected result written in the row
    bit                 fires;
    touch_t             want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;
  logic psel, penable, pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [DATA_W-1:0]  pwdata;
  logic [DATA_W-1:0]  prdata;
  logic               pready;

  mtg_evt_if evt_ch();
  mtg_res_if res_ch();

  multitouch_slot0_gesture_decoder_core DUT (
    .clk     (clk),
    .rst     (rst),
    .evt     (evt_ch),
    .res     (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow of the axis range registers and of the contact tracker
  logic [VALUE_W-1:0] axis_reg [4];
  bit                 in_slot0;
  bit                 contact;
  logic [VALUE_W-1:0] cur_x, cur_y;
  bit                 touching;
  logic [VALUE_W-1:0] prev_x, prev_y;

  touch_t    pending_touches [$];
  stim_row_t directed_rows [$];
  int        errors;
  int        live_items;
  int        cycles;
  bit        idle_on;
  int        rx_hold_reqs;

  task automatic log_error(string msg);
    $display("ERROR @%0d: %s", cycles, msg);
    errors++;
  endtask

  // Fraction of the axis range, 16 fraction bits, clamped at both ends
  function automatic logic [NORM_W-1:0] norm_axis(logic [VALUE_W-1:0] v,
                                                  logic [VALUE_W-1:0] lo,
                                                  logic [VALUE_W-1:0] hi);
    longint span, off;
    span = longint'($signed(hi)) - longint'($signed(lo));
    off  = longint'($signed(v)) - longint'($signed(lo));
    if (span <= 0 || off <= 0) return '0;
    if (off >= span) return NORM_W'(64'd1 << FRACTION_BITS);
    return NORM_W'((off << FRACTION_BITS) / span);
  endfunction

  // Advance the tracker by one accepted event; report any touch result
  function automatic void apply_event(input logic [TYPE_W-1:0] t,
                                      input logic [CODE_W-1:0] c,
                                      input logic [VALUE_W-1:0] v,
                                      output bit fires, output touch_t got);
    fires = 1'b0;
    got   = '0;
    if (t == TYPE_ABS) begin
      case (c)
        CODE_SLOT:  in_slot0 = (v == '0);
        CODE_TRACK: if (in_slot0) contact = !v[VALUE_W-1];
        CODE_POS_X: if (in_slot0) cur_x = v;
        CODE_POS_Y: if (in_slot0) cur_y = v;
        default: ;
      endcase
    end else if (t == TYPE_SYN && c == CODE_REPORT) begin
      got.nx = norm_axis(cur_x, axis_reg[REG_X_MIN], axis_reg[REG_X_MAX]);
      got.ny = norm_axis(cur_y, axis_reg[REG_Y_MIN], axis_reg[REG_Y_MAX]);
      if (contact && !touching) begin
        got.kind = KIND_DOWN;
        fires    = 1'b1;
      end else if (!contact && touching) begin
        got.kind = KIND_UP;
        fires    = 1'b1;
      end else if (contact && (cur_x != prev_x || cur_y != prev_y)) begin
        got.kind = KIND_MOVE;
        fires    = 1'b1;
      end
      touching = contact;
      prev_x   = cur_x;
      prev_y   = cur_y;
    end
  endfunction

  // Stall length: mostly short, a few long
  function automatic int stall_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int pick_gap();
    if (!idle_on || $urandom_range(0, 9) < 7) return 0;
    return stall_len();
  endfunction

  // Coordinate around the configured range, edges and outliers included
  function automatic logic [VALUE_W-1:0] pick_coord(logic [VALUE_W-1:0] lo,
                                                    logic [VALUE_W-1:0] hi);
    longint a, b, span;
    logic [63:0] rnd;
    int r;
    a   = longint'($signed(lo));
    b   = longint'($signed(hi));
    r   = $urandom_range(0, 9);
    rnd = {$urandom, $urandom};
    if (r == 0 || b <= a) return $urandom;
    if (r == 1) return lo;
    if (r == 2) return hi;
    if (r == 3) return lo - 1;
    if (r == 4) return hi + 1;
    span = b - a + 1;
    return VALUE_W'(a + longint'(rnd % 64'(span)));
  endfunction

  function automatic stim_row_t mk_row(logic [TYPE_W-1:0] t, logic [CODE_W-1:0] c,
                                       logic [VALUE_W-1:0] v, bit typed, bit fires,
                                       kind_t k, int nx, int ny);
    stim_row_t row;
    row.etype  = t;
    row.ecode  = c;
    row.evalue = v;
    row.typed  = typed;
    row.fires  = fires;
    row.want   = '{k, NORM_W'(nx), NORM_W'(ny)};
    return row;
  endfunction

  // One event beat: driven at the falling edge, taken at a rising edge
  task automatic send_event(logic [TYPE_W-1:0] t, logic [CODE_W-1:0] c,
                            logic [VALUE_W-1:0] v, int gap,
                            bit typed = 1'b0, bit fires = 1'b0,
                            touch_t want = '0);
    bit     pf;
    touch_t pr;
    if (gap > 0) begin
      @(negedge clk);
      evt_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    evt_ch.valid       <= 1'b1;
    evt_ch.event_type  <= t;
    evt_ch.event_code  <= c;
    evt_ch.event_value <= v;
    do @(posedge clk); while (!evt_ch.ready);
    apply_event(t, c, v, pf, pr);
    if (typed) begin
      if (fires) pending_touches.push_back(want);
    end else if (pf) begin
      pending_touches.push_back(pr);
    end
    if ((t == TYPE_ABS && (c == CODE_SLOT || c == CODE_TRACK ||
                           c == CODE_POS_X || c == CODE_POS_Y)) ||
        (t == TYPE_SYN && c == CODE_REPORT))
      live_items++;
  endtask

  task automatic end_events();
    @(negedge clk);
    evt_ch.valid <= 1'b0;
  endtask

  // Wait for every expected result, then let the core settle
  task automatic drain();
    while (pending_touches.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(reg_idx_t idx, logic [DATA_W-1:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    axis_reg[idx] = val;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic cfg_read(reg_idx_t idx, output logic [DATA_W-1:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    val = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Load all four range registers and read them back
  task automatic load_ranges(logic [VALUE_W-1:0] xlo, logic [VALUE_W-1:0] xhi,
                             logic [VALUE_W-1:0] ylo, logic [VALUE_W-1:0] yhi);
    logic [DATA_W-1:0] rd;
    cfg_write(REG_X_MIN, xlo);
    cfg_write(REG_X_MAX, xhi);
    cfg_write(REG_Y_MIN, ylo);
    cfg_write(REG_Y_MAX, yhi);
    for (int i = 0; i < 4; i++) begin
      cfg_read(reg_idx_t'(i), rd);
      if (rd !== axis_reg[i])
        log_error($sformatf("register %0d reads %h, holds %h", i, rd, axis_reg[i]));
    end
  endtask

  // One protocol frame: optional slot, tracking id, position and noise beats, then a report
  task automatic send_frame(bit burst);
    int r;
    logic [VALUE_W-1:0] v;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      v = $urandom;
      if (v == '0) v = 1;
      send_event(TYPE_ABS, CODE_SLOT, v, burst ? 0 : pick_gap());
    end else if (r < 20 || !in_slot0) begin
      send_event(TYPE_ABS, CODE_SLOT, '0, burst ? 0 : pick_gap());
    end
    r = $urandom_range(0, 99);
    if ((!contact && r < 50) || r < 8) begin
      v = $urandom;
      if (!contact) v[VALUE_W-1] = 1'b0;
      else if ($urandom_range(0, 1)) v = -1;
      send_event(TYPE_ABS, CODE_TRACK, v, burst ? 0 : pick_gap());
    end
    if ($urandom_range(0, 9) < 7)
      send_event(TYPE_ABS, CODE_POS_X, pick_coord(axis_reg[REG_X_MIN], axis_reg[REG_X_MAX]),
                 burst ? 0 : pick_gap());
    if ($urandom_range(0, 9) < 7)
      send_event(TYPE_ABS, CODE_POS_Y, pick_coord(axis_reg[REG_Y_MIN], axis_reg[REG_Y_MAX]),
                 burst ? 0 : pick_gap());
    // noise: random beats, sync with a nonzero code, axis codes out of place
    r = $urandom_range(0, 99);
    if (r < 10)
      send_event(TYPE_W'($urandom), CODE_W'($urandom), $urandom, burst ? 0 : pick_gap());
    else if (r < 14)
      send_event(TYPE_SYN, CODE_W'($urandom_range(1, 1023)), $urandom,
                 burst ? 0 : pick_gap());
    else if (r < 17)
      send_event(TYPE_ABS, CODE_W'($urandom), $urandom, burst ? 0 : pick_gap());
    send_event(TYPE_SYN, CODE_REPORT, $urandom, burst ? 0 : pick_gap());
  endtask

  // Directed rows: reset ranges first, then fixed ranges
  task automatic fill_directed();
    directed_rows.push_back(mk_row(TYPE_SYN, CODE_REPORT, 0, 1, 0, KIND_DOWN, 0, 0));
    directed_rows.push_back(mk_row(TYPE_ABS, CODE_TRACK, 5, 0, 0, KIND_DOWN, 0, 0));
    directed_rows.push_back(mk_row(TYPE_ABS, CODE_POS_X, 123, 0, 0, KIND_DOWN, 0, 0));
    directed_rows.push_back(mk_row(TYPE_ABS, CODE_POS_Y, -7, 0, 0, KIND_DOWN, 0, 0));
    directed_rows.push_back(mk_row(TYPE_SYN, CODE_REPORT, 0, 1, 1, KIND_DOWN, 0, 0));
    // X -1000..1000, Y over the whole signed range
    directed_rows.push_back(mk_row(TYPE_ABS, CODE_POS_X, 1000, 0, 0, KIND_DOWN, 0, 0));
    directed_rows.push_back(mk_row(TYPE_ABS, CODE_POS_Y, 32'h7fffffff, 0, 0, KIND_DOWN, 0, 0));
    directed_rows.push_back(mk_row(TYPE_SYN, CODE_REPORT, 0, 1, 1, KIND_MOVE, 65536, 65536));
    directed_rows.push_back(mk_row(TYPE_ABS, CODE_POS_X, -5000, 0, 0, KIND_DOWN, 0, 0));
    directed_rows.push_back(mk_row(TYPE_ABS, CODE_POS_Y, 32'h80000000, 0, 0, KIND_DOWN, 0, 0));
    directed_rows.push_back(mk_row(TYPE_SYN, CODE_REPORT, 0, 1, 1, KIND_MOVE, 0, 0));
    directed_rows.push_back(mk_row(TYPE_ABS, CODE_POS_X, 0, 0, 0, KIND_DOWN, 0, 0));
    directed_rows.push_back(mk_row(TYPE_ABS, CODE_POS_Y, 0, 0, 0, KIND_DOWN, 0, 0));
    directed_rows.push_back(mk_row(TYPE_SYN, CODE_REPORT, 0, 0, 0, KIND_DOWN, 0, 0));
    // slot 1 selected: position and tracking id ignored, report unchanged
    directed_rows.push_back(mk_row(TYPE_ABS, CODE_SLOT, 1, 0, 0, KIND_DOWN, 0, 0));
    directed_rows.push_back(mk_row(TYPE_ABS, CODE_POS_X, 77, 0, 0, KIND_DOWN, 0, 0));
    directed_rows.push_back(mk_row(TYPE_ABS, CODE_TRACK, -1, 0, 0, KIND_DOWN, 0, 0));
    directed_rows.push_back(mk_row(TYPE_SYN, CODE_REPORT, 0, 1, 0, KIND_DOWN, 0, 0));
    // negative slot number also deselects
    directed_rows.push_back(mk_row(TYPE_ABS, CODE_SLOT, 32'h80000000, 0, 0, KIND_DOWN, 0, 0));
    directed_rows.push_back(mk_row(TYPE_ABS, CODE_SLOT, 0, 0, 0, KIND_DOWN, 0, 0));
    // lift: touch up carries the last position
    directed_rows.push_back(mk_row(TYPE_ABS, CODE_TRACK, -1, 0, 0, KIND_DOWN, 0, 0));
    directed_rows.push_back(mk_row(TYPE_SYN, CODE_REPORT, 0, 0, 0, KIND_DOWN, 0, 0));
    // ignored beats: other class, sync with nonzero code
    directed_rows.push_back(mk_row(5'd31, 10'h3ff, -1, 0, 0, KIND_DOWN, 0, 0));
    directed_rows.push_back(mk_row(TYPE_SYN, 10'h001, 0, 0, 0, KIND_DOWN, 0, 0));
    directed_rows.push_back(mk_row(TYPE_ABS, CODE_TRACK, 32'h7fffffff, 0, 0, KIND_DOWN, 0, 0));
    directed_rows.push_back(mk_row(TYPE_SYN, CODE_REPORT, 0, 0, 0, KIND_DOWN, 0, 0));
  endtask

  // Result side: compare each beat with the oldest expectation
  task automatic check_result();
    touch_t want;
    if (pending_touches.size() == 0) begin
      log_error($sformatf("unexpected result kind %0d x %0d y %0d",
                          res_ch.touch_kind, res_ch.norm_x, res_ch.norm_y));
      return;
    end
    want = pending_touches.pop_front();
    if (res_ch.touch_kind !== want.kind)
      log_error($sformatf("touch_kind %0d, expected %0d", res_ch.touch_kind, want.kind));
    if (res_ch.norm_x !== want.nx)
      log_error($sformatf("norm_x %0d, expected %0d", res_ch.norm_x, want.nx));
    if (res_ch.norm_y !== want.ny)
      log_error($sformatf("norm_y %0d, expected %0d", res_ch.norm_y, want.ny));
  endtask

  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) check_result();
  end

  // Run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= TIMEOUT_CYCLES) begin
      $display("multitouch_slot0_gesture_decoder_core_tb failed");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold-off on request
  initial begin
    int rx_stall;
    int hold_seen;
    rx_stall     = 0;
    hold_seen    = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_seen != rx_hold_reqs) begin
        hold_seen = rx_hold_reqs;
        rx_stall  = HOLD_CYCLES;
      end
      if (rx_stall > 0) begin
        res_ch.ready <= 1'b0;
        rx_stall--;
      end else begin
        res_ch.ready <= 1'b1;
        if (idle_on && $urandom_range(0, 3) == 0) rx_stall = stall_len();
      end
    end
  end

  // Stimulus
  initial begin
    int set_no;
    logic [VALUE_W-1:0] lo_x, lo_y;
    errors       = 0;
    live_items   = 0;
    cycles       = 0;
    idle_on      = 1'b1;
    rx_hold_reqs = 0;
    rst          = 1'b1;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    evt_ch.valid       = 1'b0;
    evt_ch.event_type  = '0;
    evt_ch.event_code  = '0;
    evt_ch.event_value = '0;
    for (int i = 0; i < 4; i++) axis_reg[i] = '0;
    in_slot0 = 1'b1;
    contact  = 1'b0;
    cur_x    = '0;
    cur_y    = '0;
    touching = 1'b0;
    prev_x   = '0;
    prev_y   = '0;
    fill_directed();

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part, reset ranges then fixed ranges
    foreach (directed_rows[i]) begin
      if (i == DIRECTED_SPLIT) begin
        end_events();
        drain();
        load_ranges(-1000, 1000, 32'h80000000, 32'h7fffffff);
      end
      send_event(directed_rows[i].etype, directed_rows[i].ecode, directed_rows[i].evalue,
                 pick_gap(), directed_rows[i].typed, directed_rows[i].fires,
                 directed_rows[i].want);
    end
    end_events();

    // Random part: one range setting per set of frames
    live_items = 0;
    set_no     = 0;
    while (live_items < TARGET_ITEMS) begin
      drain();
      lo_x = $urandom;
      lo_y = $urandom;
      case (set_no % 6)
        0: load_ranges(0, 0, 0, 0);
        1: load_ranges(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
        2: load_ranges(32'h7fffffff, 32'h80000000, 5, 5);
        3: load_ranges(0, 1, -3, 3);
        4: load_ranges(lo_x, lo_x + $urandom_range(1, 4096), lo_y,
                       lo_y + $urandom_range(1, 4096));
        default: load_ranges($urandom, $urandom, $urandom, $urandom);
      endcase
      idle_on = (set_no % 4 != 3);
      // output held off while frames keep coming back to back
      if (set_no == 1) begin
        rx_hold_reqs++;
        repeat (30) send_frame(1'b1);
      end
      repeat (FRAMES_PER_SET) send_frame(1'b0);
      end_events();
      set_no++;
    end
    idle_on = 1'b1;

    drain();
    if (errors == 0)
      $display("multitouch_slot0_gesture_decoder_core_tb passed");
    else
      $display("multitouch_slot0_gesture_decoder_core_tb failed");
    $finish;
  end

endmodule

`default_nettype wire
